>>> rtl/psc_pkg.sv
package psc_pkg;

  localparam int IDX_W    = 8;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_DUP       = 3'd2,
    ST_REDUCIBLE = 3'd3,
    ST_IDENTITY  = 3'd4,
    ST_TOO_MANY  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_WALK,
    S_RESULT
  } state_t;

endpackage

>>> rtl/psc_ram.sv
module psc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/permutation_single_cycle_check_core.sv
// channel | direction | handshake           | payload
// in_     | input     | in_valid, in_stall   | in_index_value[7:0], in_is_last
// out_    | output    | out_valid, out_stall | out_status[2:0], out_cycle_length[4:0]
//
// loading takes one item per cycle, stored at the next free entry of the index memory
// after the last item: a scan over the memory (range, duplicate, moved positions), then
// a cycle walk of one memory read per step, then the result state that loads the
// result register
// an overflowed list skips the scan and walk and goes to the result state after its last item
// synchronous active-low reset clears control state only, the index memory needs no clearing
// input stalls outside loading; out_stall holds the result register, and a new list can
// load while a result waits
module permutation_single_cycle_check_core
  import psc_pkg::*;
#(
  parameter int MAX_N = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [IDX_W-1:0]    in_index_value,
  input  logic                in_is_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [LEN_W-1:0]    out_cycle_length
);

  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CW = $clog2(MAX_N + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     elem_cnt_r, elem_cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [MAX_N-1:0]  seen_r, seen_nxt;
  status_t           err_r, err_nxt;
  logic [CW-1:0]     moved_r, moved_nxt;
  logic [AW-1:0]     start_r, start_nxt;
  logic [CW-1:0]     scan_left_r, scan_left_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     steps_r, steps_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [LEN_W-1:0]  res_len_r, res_len_nxt;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [LEN_W-1:0]  out_len_r;

  logic              in_xfer;
  logic              out_load;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [IDX_W-1:0]  ram_rdata;
  logic [CW-1:0]     steps_inc;

  psc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_N)
  ) u_idx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_index_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_LOAD);
  assign in_xfer   = in_valid && !in_stall;
  assign ram_waddr = elem_cnt_r[AW-1:0];
  assign steps_inc = CW'(steps_r + 1'b1);

  always_comb begin
    state_nxt      = state_r;
    elem_cnt_nxt   = elem_cnt_r;
    ovf_nxt        = ovf_r;
    seen_nxt       = seen_r;
    err_nxt        = err_r;
    moved_nxt      = moved_r;
    start_nxt      = start_r;
    scan_left_nxt  = scan_left_r;
    pend_nxt       = 1'b0;
    pos_nxt        = pos_r;
    steps_nxt      = steps_r;
    res_status_nxt = res_status_r;
    res_len_nxt    = res_len_r;
    ram_we         = 1'b0;
    ram_raddr      = '0;
    out_load       = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (elem_cnt_r < CW'(MAX_N)) begin
            ram_we       = 1'b1;
            elem_cnt_nxt = CW'(elem_cnt_r + 1'b1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) begin
            if (ovf_nxt) begin
              res_status_nxt = ST_TOO_MANY;
              res_len_nxt    = '0;
              state_nxt      = S_RESULT;
            end else begin
              scan_left_nxt = elem_cnt_nxt;
              seen_nxt      = '0;
              err_nxt       = ST_OK;
              moved_nxt     = '0;
              state_nxt     = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        // descending scan, so the lowest failing position is the one kept
        if (scan_left_r != '0) begin
          ram_raddr     = AW'(scan_left_r - 1'b1);
          pend_nxt      = 1'b1;
          pos_nxt       = AW'(scan_left_r - 1'b1);
          scan_left_nxt = CW'(scan_left_r - 1'b1);
        end
        if (pend_r) begin
          if (ram_rdata >= IDX_W'(elem_cnt_r)) begin
            err_nxt = ST_RANGE;
          end else begin
            if (seen_r[ram_rdata[AW-1:0]]) begin
              err_nxt = ST_DUP;
            end
            seen_nxt[ram_rdata[AW-1:0]] = 1'b1;
          end
          if (ram_rdata != IDX_W'(pos_r)) begin
            moved_nxt = CW'(moved_r + 1'b1);
            start_nxt = pos_r;
          end
        end
        if (scan_left_r == '0 && !pend_r) begin
          if (err_r != ST_OK) begin
            res_status_nxt = err_r;
            res_len_nxt    = '0;
            state_nxt      = S_RESULT;
          end else if (moved_r == '0) begin
            res_status_nxt = ST_IDENTITY;
            res_len_nxt    = '0;
            state_nxt      = S_RESULT;
          end else begin
            ram_raddr = start_r;
            steps_nxt = '0;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (ram_rdata == IDX_W'(start_r)) begin
          if (steps_inc == moved_r) begin
            res_status_nxt = ST_OK;
            res_len_nxt    = LEN_W'(steps_inc);
          end else begin
            res_status_nxt = ST_REDUCIBLE;
            res_len_nxt    = '0;
          end
          state_nxt = S_RESULT;
        end else begin
          ram_raddr = ram_rdata[AW-1:0];
          steps_nxt = steps_inc;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_load     = 1'b1;
          elem_cnt_nxt = '0;
          ovf_nxt      = 1'b0;
          state_nxt    = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      elem_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      scan_left_r <= '0;
      err_r       <= ST_OK;
      seen_r      <= '0;
      moved_r     <= '0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      scan_left_r <= scan_left_nxt;
      err_r       <= err_nxt;
      seen_r      <= seen_nxt;
      moved_r     <= moved_nxt;
      steps_r     <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_len_r    <= res_len_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_len_r    <= res_len_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_cycle_length = out_len_r;

  a_err_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_cycle_length == '0))
    else $error("nonzero cycle length on an error result");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    elem_cnt_r <= CW'(MAX_N))
    else $error("element count above capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (elem_cnt_r == CW'(MAX_N)))
    else $error("overflow flagged with free entries");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (steps_r < elem_cnt_r))
    else $error("cycle walk ran past the list length");

endmodule
